>>> rtl/fccr_pkg.sv
package fccr_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_MAX_RADIUS = 63;

	localparam int MODE_W  = 2;
	localparam int CRDIN_W = 16;
	localparam int RAD_W   = 6;
	localparam int POS_W   = 8;
	localparam int ALPHA_W = 8;
	localparam int FRAME_W = 9;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// frame sizes up to 4096, pixel coordinates with sign and margin
	localparam int DIM_W = 13;
	localparam int CRD_W = DIM_W + 1;
	localparam int DX_W  = RAD_W + 1;
	localparam int SQ_W  = 2 * RAD_W;

	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FRAME_W-1:0] FRAME_RESET = 9'd256;

	localparam logic [ALPHA_W-1:0] ALPHA_ON  = 8'hFF;
	localparam logic [ALPHA_W-1:0] ALPHA_OFF = 8'h00;

	typedef struct packed {
		logic take;
		logic clr_en;
		logic col_next;
		logic sqrt_start;
		logic span_calc;
		logic row_wr;
		logic rd_issue;
		logic rd_capture;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              clr_last;
		logic              col_ok;
		logic              dx_last;
		logic              sqrt_done;
		logic              span_ok;
		logic              row_last;
		logic              out_free;
	} sts_t;

endpackage

>>> rtl/fccr_if.sv
interface fccr_cmd_if;
	import fccr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [MODE_W-1:0]         mode;
	logic signed [CRDIN_W-1:0] center_x;
	logic signed [CRDIN_W-1:0] center_y;
	logic [RAD_W-1:0]          radius;
	logic [POS_W-1:0]          read_col;
	logic [POS_W-1:0]          read_row;

	modport source (
		output valid, mode, center_x, center_y, radius, read_col, read_row,
		input  ready
	);
	modport sink (
		input  valid, mode, center_x, center_y, radius, read_col, read_row,
		output ready
	);
endinterface

interface fccr_res_if;
	import fccr_pkg::*;

	logic               valid;
	logic               ready;
	logic [ALPHA_W-1:0] alpha;
	logic [MODE_W-1:0]  done_mode;

	modport source (
		output valid, alpha, done_mode,
		input  ready
	);
	modport sink (
		input  valid, alpha, done_mode,
		output ready
	);
endinterface

>>> rtl/fccr_isqrt.sv
module fccr_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fccr_pkg::SQ_W-1:0]  n,
	output logic                       done,
	output logic [fccr_pkg::RAD_W-1:0] root,
	output logic [fccr_pkg::RAD_W:0]   rem
);
	import fccr_pkg::*;

	localparam int STEPS = SQ_W / 2;
	localparam int CNT_W = $clog2(STEPS);
	localparam int T_W   = RAD_W + 3;

	logic [SQ_W-1:0]  n_q;
	logic [RAD_W-1:0] root_q;
	logic [RAD_W:0]   rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [T_W-1:0] tmp;
	logic [T_W-1:0] trial;
	logic [T_W-1:0] diff;
	logic           ge;

	// bring down two bits of n, try subtracting 4*root+1
	assign tmp   = {rem_q, n_q[SQ_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = tmp >= trial;
	assign diff  = tmp - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= n;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			n_q    <= n_q << 2;
			root_q <= {root_q[RAD_W-2:0], ge};
			rem_q  <= ge ? diff[RAD_W:0] : tmp[RAD_W:0];
		end
	end

	assign done = done_q;
	assign root = root_q;
	assign rem  = rem_q;

endmodule

>>> rtl/fccr_mask_mem.sv
module fccr_mask_mem #(
	parameter int BB = 4,
	parameter int AW = 12
) (
	input  logic               clk,
	input  logic [(1<<BB)-1:0] we,
	input  logic [AW-1:0]      waddr,
	input  logic               wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	input  logic [BB-1:0]      rbank,
	output logic               rbit
);
	localparam int NB    = 1 << BB;
	localparam int DEPTH = 1 << AW;

	logic [NB-1:0] rdata;
	logic [BB-1:0] rbank_q;

	for (genvar b = 0; b < NB; b++) begin : g_bank
		logic mem [DEPTH];
		logic rd_q;

		always_ff @(posedge clk) begin
			if (we[b])
				mem[waddr] <= wdata;
			if (re)
				rd_q <= mem[raddr];
		end

		assign rdata[b] = rd_q;
	end

	always_ff @(posedge clk) begin
		if (re)
			rbank_q <= rbank;
	end

	assign rbit = rdata[rbank_q];

endmodule

>>> rtl/fccr_datapath.sv
module fccr_datapath #(
	parameter int MAX_WIDTH  = fccr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = fccr_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = fccr_pkg::DEF_MAX_RADIUS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fccr_pkg::ctl_t               ctl,
	output fccr_pkg::sts_t               sts,
	input  logic [fccr_pkg::FRAME_W-1:0] frame_width,
	input  logic [fccr_pkg::FRAME_W-1:0] frame_height,
	input  logic [fccr_pkg::MODE_W-1:0]  mode,
	input  logic signed [fccr_pkg::CRDIN_W-1:0] center_x,
	input  logic signed [fccr_pkg::CRDIN_W-1:0] center_y,
	input  logic [fccr_pkg::RAD_W-1:0]   radius,
	input  logic [fccr_pkg::POS_W-1:0]   read_col,
	input  logic [fccr_pkg::POS_W-1:0]   read_row,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [fccr_pkg::ALPHA_W-1:0] alpha,
	output logic [fccr_pkg::MODE_W-1:0]  done_mode
);
	import fccr_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int BB   = (CW > 4) ? 4 : CW - 1;
	localparam int NB   = 1 << BB;
	localparam int AW   = RW + CW - BB;
	localparam int VE_W = CRDIN_W + 1;
	localparam int H_W  = RAD_W + 1;

	function automatic logic signed [CRD_W-1:0] round_q4(input logic signed [CRDIN_W-1:0] v);
		logic signed [VE_W-1:0] ve;
		logic [VE_W-1:0]        mag;
		logic [VE_W-1:0]        q;
		logic signed [CRD_W-1:0] r;
		ve  = VE_W'(v);
		mag = ve[VE_W-1] ? -ve : ve;
		q   = (mag + VE_W'(8)) >> 4;
		r   = $signed(q[CRD_W-1:0]);
		return ve[VE_W-1] ? -r : r;
	endfunction

	// effective frame size, limited to the mask size
	logic [DIM_W-1:0] fw_ext, fh_ext, effw, effh;
	assign fw_ext = DIM_W'(frame_width);
	assign fh_ext = DIM_W'(frame_height);
	assign effw   = (fw_ext > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : fw_ext;
	assign effh   = (fh_ext > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : fh_ext;

	logic signed [CRD_W-1:0] effw_s, effh_s, hlim;
	assign effw_s = $signed({1'b0, effw});
	assign effh_s = $signed({1'b0, effh});
	assign hlim   = effh_s - $signed(CRD_W'(1));

	// request fields at acceptance
	logic [RAD_W-1:0] rad_c;
	logic [SQ_W-1:0]  rad_ext;
	logic [DIM_W-1:0] rc_ext, rr_ext;
	assign rad_c   = (int'(radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius;
	assign rad_ext = SQ_W'(rad_c);
	assign rc_ext  = DIM_W'(read_col);
	assign rr_ext  = DIM_W'(read_row);

	logic [MODE_W-1:0]       mode_q;
	logic signed [CRD_W-1:0] cx_q, cy_q;
	logic [RAD_W-1:0]        r_q;
	logic [SQ_W-1:0]         r2_q;
	logic signed [DX_W-1:0]  dx_q;
	logic                    rd_ok_q;
	logic [CW-1:0]           rd_col_q;
	logic [RW-1:0]           rd_row_q;
	logic [ALPHA_W-1:0]      alpha_q;
	logic [CW-1:0]           col_q;
	logic [RW-1:0]           row_q, row_hi_q;
	logic                    span_ok_q;

	// column walk
	logic signed [CRD_W-1:0] col_s;
	logic [DX_W-1:0]         adx;
	logic [SQ_W-1:0]         adx_ext;
	logic [SQ_W-1:0]         n_val;
	logic                    col_ok, dx_last;

	assign col_s   = cx_q + CRD_W'(dx_q);
	assign col_ok  = !col_s[CRD_W-1] && (col_s < effw_s);
	assign dx_last = dx_q == $signed({1'b0, r_q});
	assign adx     = dx_q[DX_W-1] ? -dx_q : dx_q;
	assign adx_ext = SQ_W'(adx[RAD_W-1:0]);
	assign n_val   = r2_q - adx_ext * adx_ext;

	logic             sq_done;
	logic [RAD_W-1:0] sq_root;
	logic [RAD_W:0]   sq_rem;

	fccr_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.sqrt_start),
		.n      (n_val),
		.done   (sq_done),
		.root   (sq_root),
		.rem    (sq_rem)
	);

	// round to nearest: one more when n - s*s exceeds s
	logic [H_W-1:0]          root_ext, half;
	logic signed [CRD_W-1:0] half_s, lo_s, hi_s, lo_c, hi_c;
	logic                    span_ok;

	assign root_ext = {1'b0, sq_root};
	assign half     = root_ext + H_W'(sq_rem > root_ext);
	assign half_s   = $signed(CRD_W'(half));
	assign lo_s     = cy_q - half_s;
	assign hi_s     = cy_q + half_s;
	assign lo_c     = lo_s[CRD_W-1] ? '0 : lo_s;
	assign hi_c     = (hi_s > hlim) ? hlim : hi_s;
	assign span_ok  = lo_c <= hi_c;

	logic [AW-1:0] clr_cnt_q;
	logic          rd_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (ctl.clr_en)
			clr_cnt_q <= clr_cnt_q + AW'(1);
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			mode_q   <= mode;
			cx_q     <= round_q4(center_x);
			cy_q     <= round_q4(center_y);
			r_q      <= rad_c;
			r2_q     <= rad_ext * rad_ext;
			dx_q     <= -$signed({1'b0, rad_c});
			rd_ok_q  <= (rc_ext < effw) && (rr_ext < effh);
			rd_col_q <= rc_ext[CW-1:0];
			rd_row_q <= rr_ext[RW-1:0];
			alpha_q  <= ALPHA_OFF;
		end
		if (ctl.col_next)
			dx_q <= dx_q + $signed(DX_W'(1));
		if (ctl.sqrt_start)
			col_q <= col_s[CW-1:0];
		if (ctl.span_calc) begin
			row_q     <= lo_c[RW-1:0];
			row_hi_q  <= hi_c[RW-1:0];
			span_ok_q <= span_ok;
		end else if (ctl.row_wr) begin
			row_q <= row_q + RW'(1);
		end
		if (ctl.rd_capture)
			alpha_q <= (rd_ok_q && rd_bit) ? ALPHA_ON : ALPHA_OFF;
	end

	// mask write port: clear sweep hits every bank, drawing one bank
	logic [NB-1:0] we;
	logic [AW-1:0] waddr;

	assign waddr = ctl.clr_en ? clr_cnt_q : {row_q, col_q[CW-1:BB]};
	assign we    = ctl.clr_en ? '1 : (ctl.row_wr ? (NB'(1) << col_q[BB-1:0]) : '0);

	fccr_mask_mem #(
		.BB (BB),
		.AW (AW)
	) u_mask (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (!ctl.clr_en),
		.re    (ctl.rd_issue),
		.raddr ({rd_row_q, rd_col_q[CW-1:BB]}),
		.rbank (rd_col_q[BB-1:0]),
		.rbit  (rd_bit)
	);

	// result register
	logic               out_valid_q;
	logic [ALPHA_W-1:0] out_alpha_q;
	logic [MODE_W-1:0]  out_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.out_load)
			out_valid_q <= 1'b1;
		else if (res_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_alpha_q <= alpha_q;
			out_mode_q  <= mode_q;
		end
	end

	assign res_valid = out_valid_q;
	assign alpha     = out_alpha_q;
	assign done_mode = out_mode_q;

	always_comb begin
		sts.mode      = mode_q;
		sts.clr_last  = &clr_cnt_q;
		sts.col_ok    = col_ok;
		sts.dx_last   = dx_last;
		sts.sqrt_done = sq_done;
		sts.span_ok   = span_ok_q;
		sts.row_last  = row_q == row_hi_q;
		sts.out_free  = !out_valid_q || res_ready;
	end

endmodule

>>> rtl/fccr_ctrl.sv
module fccr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  fccr_pkg::sts_t sts,
	output fccr_pkg::ctl_t ctl
);
	import fccr_pkg::*;

	typedef enum logic [10:0] {
		S_INIT     = 11'b000_0000_0001,
		S_IDLE     = 11'b000_0000_0010,
		S_DISPATCH = 11'b000_0000_0100,
		S_CLEAR    = 11'b000_0000_1000,
		S_COL      = 11'b000_0001_0000,
		S_SQRT     = 11'b000_0010_0000,
		S_SPAN     = 11'b000_0100_0000,
		S_ROWS     = 11'b000_1000_0000,
		S_READ     = 11'b001_0000_0000,
		S_RDATA    = 11'b010_0000_0000,
		S_DONE     = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_INIT;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		cmd_ready = 1'b0;
		unique case (state_q)
			S_INIT: begin
				ctl.clr_en = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctl.take = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.mode)
					MODE_CLEAR: state_d = S_CLEAR;
					MODE_DRAW:  state_d = S_COL;
					MODE_READ:  state_d = S_READ;
					default:    state_d = S_DONE;
				endcase
			end
			S_CLEAR: begin
				ctl.clr_en = 1'b1;
				if (sts.clr_last)
					state_d = S_DONE;
			end
			S_COL: begin
				if (sts.col_ok) begin
					ctl.sqrt_start = 1'b1;
					state_d        = S_SQRT;
				end else if (sts.dx_last) begin
					state_d = S_DONE;
				end else begin
					ctl.col_next = 1'b1;
				end
			end
			S_SQRT: begin
				if (sts.sqrt_done)
					state_d = S_SPAN;
			end
			S_SPAN: begin
				ctl.span_calc = 1'b1;
				state_d       = S_ROWS;
			end
			S_ROWS: begin
				ctl.row_wr = sts.span_ok;
				// column finished: advance or wrap up
				if (!sts.span_ok || sts.row_last) begin
					if (sts.dx_last) begin
						state_d = S_DONE;
					end else begin
						ctl.col_next = 1'b1;
						state_d      = S_COL;
					end
				end
			end
			S_READ: begin
				ctl.rd_issue = 1'b1;
				state_d      = S_RDATA;
			end
			S_RDATA: begin
				ctl.rd_capture = 1'b1;
				state_d        = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

endmodule

>>> rtl/filled_circle_coverage_raster_unit.sv
// Filled-circle coverage rasterizer with a one-bit mask per pixel.
// cmd (valid/ready) carries one request: mode 0 clears the mask, mode 1
// draws a filled circle (centre in signed Q12.4, radius in pixels), mode 2
// reads one pixel. res (valid/ready) returns one result per request:
// alpha (255 covered, else 0) and done_mode, the echo of the mode.
// Frame width and height are set over the APB port at 0x0 and 0x4.
// One request is worked at a time. A read issues the mask read, then
// captures the bit; mode 3 goes straight to the result; a clear sweeps
// all 2^(rows_bits + col_bits - bank_bits) words, 4096 at the default
// 256x256 (16 banks are swept one word a cycle); a draw skips columns
// off the frame and, for each column inside it, runs the 6-step square
// root and writes the kept rows through the single mask write port.
// After reset the same clearing sweep runs and cmd stays not ready until
// it ends; registers are writable throughout.
// The result sits in an output register: a stalled receiver holds it, and
// the next request is accepted meanwhile but completes only once it drains.
module filled_circle_coverage_raster_unit #(
	parameter int MAX_WIDTH  = fccr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = fccr_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = fccr_pkg::DEF_MAX_RADIUS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fccr_pkg::PADDR_W-1:0] paddr,
	input  logic [fccr_pkg::PDATA_W-1:0] pwdata,
	output logic [fccr_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	fccr_cmd_if.sink                     cmd,
	fccr_res_if.source                   res
);
	import fccr_pkg::*;

	logic [FRAME_W-1:0] frame_width_q, frame_height_q;
	logic               reg_sel;
	logic               wr_en;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_RESET;
			frame_height_q <= FRAME_RESET;
		end else if (wr_en) begin
			if (reg_sel == REG_FRAME_HEIGHT)
				frame_height_q <= pwdata[FRAME_W-1:0];
			else
				frame_width_q <= pwdata[FRAME_W-1:0];
		end
	end

	assign prdata = (reg_sel == REG_FRAME_HEIGHT) ? PDATA_W'(frame_height_q)
	                                              : PDATA_W'(frame_width_q);

	ctl_t ctl;
	sts_t sts;

	fccr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	fccr_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_RADIUS (MAX_RADIUS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.mode         (cmd.mode),
		.center_x     (cmd.center_x),
		.center_y     (cmd.center_y),
		.radius       (cmd.radius),
		.read_col     (cmd.read_col),
		.read_row     (cmd.read_row),
		.res_valid    (res.valid),
		.res_ready    (res.ready),
		.alpha        (res.alpha),
		.done_mode    (res.done_mode)
	);

endmodule
